### rtl/pobf_pkg.sv
// ----------------------------------------------------------------------------
// pobf_pkg: shared types and constants of the oriented box filter
// Register indexes, fixed field widths of the box set-up and its reset values.
// ----------------------------------------------------------------------------
package pobf_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int INDEX_BITS_DEFAULT = 24;

   localparam int EXT_BITS       = 16;
   localparam int ROT_BITS       = 16;
   localparam int ROT_FRAC       = 14;
   localparam int AXES           = 3;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_CENTER_Z      = 3'd2,
      CSR_EXTENT_PACKED = 3'd3,
      CSR_ROT_COL_X     = 3'd4,
      CSR_ROT_COL_Y     = 3'd5,
      CSR_ROT_COL_Z     = 3'd6
   } csr_index_type;

   // Identity rotation: Q1.14 one on the diagonal
   localparam logic [CSR_DATA_BITS-1:0] ROT_COL_X_RESET = 48'h0000_0000_4000;
   localparam logic [CSR_DATA_BITS-1:0] ROT_COL_Y_RESET = 48'h0000_4000_0000;
   localparam logic [CSR_DATA_BITS-1:0] ROT_COL_Z_RESET = 48'h4000_0000_0000;

   // rot[k][i]: column k, row i; extent[k]: full extent along axis k
   typedef struct packed {
      logic [AXES-1:0][EXT_BITS-1:0]                extent;
      logic [AXES-1:0][AXES-1:0][ROT_BITS-1:0]      rot;
   } box_cfg_type;

endpackage

### rtl/point_in_oriented_box_filter_core.sv
// ----------------------------------------------------------------------------
// point_in_oriented_box_filter_core: oriented box point filter
// Streams points in and passes on the index of each point inside the box.
// ----------------------------------------------------------------------------
// One point transfer per clock is accepted at full rate while the result
// side keeps up, and a passing index is presented once it has passed the
// point register, the product register after the nine parallel
// offset-by-rotation multipliers, and the per-axis sum,
// magnitude and extent compare that feeds the result register. Points
// outside the box give no result transfer at all. Each
// stage holds when the one after it is full and stalled, so back-pressure on
// the result side only stops input once every stage holds an item. The box
// set-up (centre, packed extents, three Q1.14 rotation columns; identity
// rotation and zero extents after reset) is written through the csr_ port
// and must only change while no point is in flight. The test is exact:
// 2*|offset . column| <= extent * 2^14 on each axis, inclusive.
module point_in_oriented_box_filter_core
   import pobf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
   localparam int REQ_BITS  = ((AXES * COORD_BITS + INDEX_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((INDEX_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // point channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // point_x, point_y, point_z, point_index, zero pad (lowest bits first)
   input  logic [REQ_BITS-1:0]         req_tdata,
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // inside_index, zero pad (lowest bits first)
   output logic [RSP_BITS-1:0]         rsp_tdata,
   // set-up write port
   input  logic                        csr_we,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [AXES-1:0][COORD_BITS-1:0]                  req_point;
   logic [INDEX_BITS-1:0]                            req_index;
   logic [AXES-1:0][COORD_BITS-1:0]                  center;
   box_cfg_type                                      box_cfg;
   logic                                             prod_valid;
   logic                                             prod_ready;
   logic [AXES-1:0][AXES-1:0][COORD_BITS+ROT_BITS:0] prod;
   logic [INDEX_BITS-1:0]                            prod_index;
   logic [INDEX_BITS-1:0]                            rsp_index;

   // unpack the point transfer; pad bits are ignored
   assign req_point = req_tdata[AXES*COORD_BITS-1:0];
   assign req_index = req_tdata[AXES*COORD_BITS +: INDEX_BITS];

   pobf_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .center    (center),
      .box_cfg   (box_cfg)
   );

   // point register, then offset and projection products
   pobf_proj #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_point  (req_point),
      .in_index  (req_index),
      .center    (center),
      .box_cfg   (box_cfg),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_prod  (prod),
      .out_index (prod_index)
   );

   // per-axis extent test; drop points outside, hold the result register
   pobf_test #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_prod   (prod),
      .in_index  (prod_index),
      .extent    (box_cfg.extent),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (rsp_index)
   );

   assign rsp_tdata = RSP_BITS'(rsp_index);

endmodule

### rtl/pobf_csr.sv
// ----------------------------------------------------------------------------
// pobf_csr: box set-up registers
// Holds centre, extents and rotation columns; writes beyond the list drop.
// ----------------------------------------------------------------------------
module pobf_csr
   import pobf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [CSR_DATA_BITS-1:0]             csr_wdata,
   output logic [AXES-1:0][COORD_BITS-1:0]      center,
   output box_cfg_type                          box_cfg
);

   logic [AXES-1:0][COORD_BITS-1:0]             center_ff;
   logic [AXES-1:0][EXT_BITS-1:0]               extent_ff;
   logic [AXES-1:0][AXES*ROT_BITS-1:0]          rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         extent_ff <= '0;
         rot_ff[0] <= ROT_COL_X_RESET;
         rot_ff[1] <= ROT_COL_Y_RESET;
         rot_ff[2] <= ROT_COL_Z_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:      center_ff[0] <= csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Y:      center_ff[1] <= csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Z:      center_ff[2] <= csr_wdata[COORD_BITS-1:0];
            CSR_EXTENT_PACKED: extent_ff    <= csr_wdata[AXES*EXT_BITS-1:0];
            CSR_ROT_COL_X:     rot_ff[0]    <= csr_wdata[AXES*ROT_BITS-1:0];
            CSR_ROT_COL_Y:     rot_ff[1]    <= csr_wdata[AXES*ROT_BITS-1:0];
            CSR_ROT_COL_Z:     rot_ff[2]    <= csr_wdata[AXES*ROT_BITS-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_comb begin
      center         = center_ff;
      box_cfg.extent = extent_ff;
      for (int k = 0; k < AXES; k++) begin
         box_cfg.rot[k] = rot_ff[k];
      end
   end

endmodule

### rtl/pobf_proj.sv
// ----------------------------------------------------------------------------
// pobf_proj: point register and projection products
// Registers the point, forms the offset from the centre and the nine
// offset-by-rotation products, and registers those.
// ----------------------------------------------------------------------------
module pobf_proj
   import pobf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [AXES-1:0][COORD_BITS-1:0]                  in_point,
   input  logic [INDEX_BITS-1:0]                            in_index,
   input  logic [AXES-1:0][COORD_BITS-1:0]                  center,
   input  box_cfg_type                                      box_cfg,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [AXES-1:0][AXES-1:0][COORD_BITS+ROT_BITS:0] out_prod,
   output logic [INDEX_BITS-1:0]                            out_index
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + ROT_BITS;

   logic                                           pt_valid_ff;
   logic [AXES-1:0][COORD_BITS-1:0]                pt_point_ff;
   logic [INDEX_BITS-1:0]                          pt_index_ff;
   logic                                           pr_valid_ff;
   logic [AXES-1:0][AXES-1:0][PROD_BITS-1:0]       pr_prod_ff;
   logic [AXES-1:0][AXES-1:0][PROD_BITS-1:0]       pr_prod_in;
   logic [INDEX_BITS-1:0]                          pr_index_ff;
   logic                                           pt_ready;
   logic signed [AXES-1:0][DIFF_BITS-1:0]          diff;

   assign pt_ready = !pr_valid_ff || out_ready;
   assign in_ready = !pt_valid_ff || pt_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else if (in_ready) begin
         pt_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pt_point_ff <= in_point;
         pt_index_ff <= in_index;
      end
   end

   always_comb begin
      logic signed [DIFF_BITS-1:0] p_ext;
      logic signed [DIFF_BITS-1:0] c_ext;
      logic signed [PROD_BITS-1:0] d_ext;
      logic signed [PROD_BITS-1:0] r_ext;
      diff       = '0;
      pr_prod_in = '0;
      for (int i = 0; i < AXES; i++) begin
         p_ext   = DIFF_BITS'(signed'(pt_point_ff[i]));
         c_ext   = DIFF_BITS'(signed'(center[i]));
         diff[i] = p_ext - c_ext;
      end
      for (int k = 0; k < AXES; k++) begin
         for (int i = 0; i < AXES; i++) begin
            d_ext            = PROD_BITS'(signed'(diff[i]));
            r_ext            = PROD_BITS'(signed'(box_cfg.rot[k][i]));
            pr_prod_in[k][i] = d_ext * r_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (pt_ready) begin
         pr_valid_ff <= pt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_valid_ff && pt_ready) begin
         pr_prod_ff  <= pr_prod_in;
         pr_index_ff <= pt_index_ff;
      end
   end

   assign out_valid = pr_valid_ff;
   assign out_prod  = pr_prod_ff;
   assign out_index = pr_index_ff;

endmodule

### rtl/pobf_test.sv
// ----------------------------------------------------------------------------
// pobf_test: extent test and result register
// Sums the products per axis, takes the magnitude and compares twice it
// against the extent scaled to Q.14; only passing points reach the output.
// ----------------------------------------------------------------------------
module pobf_test
   import pobf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [AXES-1:0][AXES-1:0][COORD_BITS+ROT_BITS:0] in_prod,
   input  logic [INDEX_BITS-1:0]                            in_index,
   input  logic [AXES-1:0][EXT_BITS-1:0]                    extent,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [INDEX_BITS-1:0]                            out_index
);

   localparam int PROD_BITS = COORD_BITS + 1 + ROT_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int LIM_BITS  = EXT_BITS + ROT_FRAC;
   localparam int CMP_BITS  = (SUM_BITS + 1 > LIM_BITS) ? SUM_BITS + 1 : LIM_BITS;

   logic                    res_valid_ff;
   logic [INDEX_BITS-1:0]   res_index_ff;
   logic                    in_box;

   always_comb begin
      logic signed [SUM_BITS-1:0] sum;
      logic [SUM_BITS-1:0]        mag;
      logic [CMP_BITS-1:0]        twice_mag;
      logic [CMP_BITS-1:0]        lim;
      in_box = 1'b1;
      for (int k = 0; k < AXES; k++) begin
         sum = SUM_BITS'(signed'(in_prod[k][0]))
             + SUM_BITS'(signed'(in_prod[k][1]))
             + SUM_BITS'(signed'(in_prod[k][2]));
         mag       = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
         twice_mag = CMP_BITS'({mag, 1'b0});
         lim       = CMP_BITS'({extent[k], {ROT_FRAC{1'b0}}});
         if (twice_mag > lim) begin
            in_box = 1'b0;
         end
      end
   end

   assign in_ready = !res_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (in_ready) begin
         res_valid_ff <= in_valid && in_box;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_index_ff <= in_index;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_index = res_index_ff;

endmodule
